/* design/cpsat_pkg.sv */
// shared types and constants of the polygon collision block
package cpsat_pkg;

  localparam int MAX_VERT = 16;
  localparam int IW = $clog2(MAX_VERT);
  localparam int AW = IW + 1;
  localparam int CW = $clog2(MAX_VERT + 1);

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               internal;
  } vtx_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_START,
    S_EDGE_I,
    S_EDGE_J,
    S_EDGE_N,
    S_NORM_GO,
    S_NORM_W,
    S_PRD,
    S_PMX,
    S_PMY,
    S_PCMP,
    S_CHECK,
    S_SHX,
    S_SHY,
    S_SHR,
    S_OUT
  } cpsat_state_e;

  typedef enum logic [3:0] {
    N_IDLE,
    N_SQX,
    N_SQY,
    N_ROOT,
    N_DLDX,
    N_DIVX,
    N_DLDY,
    N_DIVY,
    N_FINY,
    N_DONE
  } cpsat_nstate_e;

endpackage

/* design/cpsat_if.sv */
// valid/ready channels for vertex words and result words
interface cpsat_in_if;
  logic               valid;
  logic               ready;
  logic               polygon_select;
  logic signed [15:0] vertex_x;
  logic signed [15:0] vertex_y;
  logic               edge_internal;
  logic               last_vertex;

  modport source (output valid, polygon_select, vertex_x, vertex_y, edge_internal,
                  last_vertex, input ready);
  modport sink (input valid, polygon_select, vertex_x, vertex_y, edge_internal,
                last_vertex, output ready);
endinterface

interface cpsat_out_if;
  logic               valid;
  logic               ready;
  logic               collides;
  logic signed [17:0] shift_x;
  logic signed [17:0] shift_y;

  modport source (output valid, collides, shift_x, shift_y, input ready);
  modport sink (input valid, collides, shift_x, shift_y, output ready);
endinterface

/* design/cpsat_vmem.sv */
// vertex memory, polygon a in the lower half and polygon b in the upper half
module cpsat_vmem (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [cpsat_pkg::AW-1:0] waddr_i,
  input  cpsat_pkg::vtx_t        wdata_i,
  input  logic [cpsat_pkg::AW-1:0] raddr_i,
  output cpsat_pkg::vtx_t        rdata_o
);

  cpsat_pkg::vtx_t mem [2**cpsat_pkg::AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

/* design/cpsat_norm.sv */
// edge normal to unit axis in q2.14: bit-serial square root and two divisions
module cpsat_norm (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [16:0] nx_i,
  input  logic signed [16:0] ny_i,
  output logic               done_o,
  output logic signed [15:0] ax_o,
  output logic signed [15:0] ay_o
);

  cpsat_pkg::cpsat_nstate_e state_q, state_d;

  logic signed [16:0] nx_q, ny_q;
  logic [33:0] m2_q;
  logic [61:0] rad_q;
  logic [34:0] rem_q;
  logic [30:0] root_q;
  logic [4:0]  cnt_q;
  logic [47:0] drem_q;
  logic [48:0] dsh_q;
  logic [16:0] quo_q;

  logic signed [16:0] mop;
  logic signed [33:0] sq;
  logic [33:0] m2_sum;
  logic [34:0] rem_sh, trial;
  logic        root_ge, div_ge;
  logic [16:0] mag_x, mag_y;

  function automatic logic signed [15:0] sat16(input logic neg, input logic [16:0] q);
    logic signed [15:0] r;
    if (neg && q >= 17'd32768) r = -16'sd32768;
    else if (!neg && q > 17'd32767) r = 16'sd32767;
    else if (neg) r = -$signed(q[15:0]);
    else r = $signed(q[15:0]);
    return r;
  endfunction

  assign mop     = (state_q == cpsat_pkg::N_SQX) ? nx_q : ny_q;
  assign sq      = mop * mop;
  assign m2_sum  = m2_q + $unsigned(sq);
  assign rem_sh  = {rem_q[32:0], rad_q[61:60]};
  assign trial   = {2'b00, root_q, 2'b01};
  assign root_ge = rem_sh >= trial;
  assign div_ge  = {1'b0, drem_q} >= dsh_q;
  assign mag_x   = nx_q[16] ? 17'(-nx_q) : 17'(nx_q);
  assign mag_y   = ny_q[16] ? 17'(-ny_q) : 17'(ny_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cpsat_pkg::N_IDLE: if (start_i) state_d = cpsat_pkg::N_SQX;
      cpsat_pkg::N_SQX:  state_d = cpsat_pkg::N_SQY;
      cpsat_pkg::N_SQY:  state_d = (m2_sum == '0) ? cpsat_pkg::N_DONE : cpsat_pkg::N_ROOT;
      cpsat_pkg::N_ROOT: if (cnt_q == 5'd30) state_d = cpsat_pkg::N_DLDX;
      cpsat_pkg::N_DLDX: state_d = cpsat_pkg::N_DIVX;
      cpsat_pkg::N_DIVX: if (cnt_q == 5'd16) state_d = cpsat_pkg::N_DLDY;
      cpsat_pkg::N_DLDY: state_d = cpsat_pkg::N_DIVY;
      cpsat_pkg::N_DIVY: if (cnt_q == 5'd16) state_d = cpsat_pkg::N_FINY;
      cpsat_pkg::N_FINY: state_d = cpsat_pkg::N_DONE;
      cpsat_pkg::N_DONE: state_d = cpsat_pkg::N_IDLE;
      default:           state_d = cpsat_pkg::N_IDLE;
    endcase
  end

  always_comb begin
    done_o = (state_q == cpsat_pkg::N_DONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cpsat_pkg::N_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      cpsat_pkg::N_IDLE: begin
        nx_q <= nx_i;
        ny_q <= ny_i;
      end
      cpsat_pkg::N_SQX: m2_q <= $unsigned(sq);
      cpsat_pkg::N_SQY: begin
        rad_q  <= {m2_sum, 28'd0};
        rem_q  <= '0;
        root_q <= '0;
        cnt_q  <= '0;
        ax_o   <= '0;
        ay_o   <= '0;
      end
      cpsat_pkg::N_ROOT: begin
        rem_q  <= root_ge ? rem_sh - trial : rem_sh;
        root_q <= {root_q[29:0], root_ge};
        rad_q  <= {rad_q[59:0], 2'b00};
        cnt_q  <= cnt_q + 5'd1;
      end
      cpsat_pkg::N_DLDX: begin
        // rounded quotient as floor((2*mag + r) / (2*r))
        drem_q <= {2'b00, mag_x, 29'd0} + {17'd0, root_q};
        dsh_q  <= {1'b0, root_q, 1'b0, 16'd0};
        quo_q  <= '0;
        cnt_q  <= '0;
      end
      cpsat_pkg::N_DIVX, cpsat_pkg::N_DIVY: begin
        if (div_ge) drem_q <= drem_q - dsh_q[47:0];
        quo_q <= {quo_q[15:0], div_ge};
        dsh_q <= {1'b0, dsh_q[48:1]};
        cnt_q <= cnt_q + 5'd1;
      end
      cpsat_pkg::N_DLDY: begin
        ax_o   <= sat16(nx_q[16], quo_q);
        drem_q <= {2'b00, mag_y, 29'd0} + {17'd0, root_q};
        dsh_q  <= {1'b0, root_q, 1'b0, 16'd0};
        quo_q  <= '0;
        cnt_q  <= '0;
      end
      cpsat_pkg::N_FINY: ay_o <= sat16(ny_q[16], quo_q);
      default: ;
    endcase
  end

endmodule

/* design/convex_polygon_sat_mtv.sv */
// Separating axis collision test of two convex polygons with a minimum translation
// vector. Vertex words are stored until the word marked last_vertex; the block then
// is busy and takes no word until its result is in the output register. Each edge
// of each direction goes through the normalizer (square root one bit a cycle,
// then two 17-step divisions) and then projects every vertex of both polygons
// onto its axis through one shared multiplier; a gap ends the test early.
module convex_polygon_sat_mtv (
  input  logic clk_i,
  input  logic rst_ni,
  cpsat_in_if.sink    in_i,
  cpsat_out_if.source out_o
);

  cpsat_pkg::cpsat_state_e state_q, state_d;

  logic [cpsat_pkg::CW-1:0] na_q, nb_q, i_q, k_q;
  logic dir_q, ph_q, first_q, usea_q;
  logic signed [15:0] xi_q, yi_q;
  logic int_q;
  logic signed [16:0] nx_q, ny_q;
  logic signed [15:0] ax_q, ay_q, bax_q, bay_q, aax_q, aay_q;
  logic [33:0] pen_q, pena_q;
  logic signed [32:0] dot_q, pmn_q, pmx_q, qmn_q, qmx_q;
  logic signed [50:0] mul_q;
  logic res_coll_q;
  logic signed [17:0] resx_q, resy_q;
  logic out_valid_q;
  logic out_coll_q;
  logic signed [17:0] out_x_q, out_y_q;

  logic in_acc, we, norm_start, norm_done;
  logic [cpsat_pkg::AW-1:0] waddr, raddr;
  cpsat_pkg::vtx_t wdata, rdata;
  logic signed [15:0] norm_ax, norm_ay;

  logic psel, csel;
  logic [cpsat_pkg::CW-1:0] np, ncur, j_idx;
  logic signed [34:0] mop_a;
  logic signed [15:0] mop_b;
  logic signed [50:0] mul;
  logic gap;
  logic signed [33:0] diff;
  logic [33:0] pen_now;
  logic out_free;

  function automatic logic signed [17:0] rnd_sat(input logic signed [50:0] v,
                                                   input logic flip);
    logic [50:0] mag;
    logic [50:0] sum;
    logic signed [23:0] s;
    logic signed [17:0] r;
    mag = v[50] ? 51'(-v) : 51'(v);
    sum = mag + 51'd134217728;
    s = (v[50] ^ flip) ? -$signed({1'b0, sum[50:28]}) : $signed({1'b0, sum[50:28]});
    if (s > 24'sd131071) r = 18'sd131071;
    else if (s < -24'sd131072) r = -18'sd131072;
    else r = s[17:0];
    return r;
  endfunction

  assign in_acc   = in_i.valid && in_i.ready;
  assign psel     = dir_q;
  assign csel     = ph_q ? ~dir_q : dir_q;
  assign np       = dir_q ? nb_q : na_q;
  assign ncur     = csel ? nb_q : na_q;
  assign j_idx    = (i_q + 1'b1 < np) ? i_q + 1'b1 : '0;
  assign mul      = mop_a * mop_b;
  assign gap      = (pmx_q < qmn_q) || (pmn_q > qmx_q);
  assign diff     = 34'(pmn_q) - 34'(qmx_q);
  assign pen_now  = diff[33] ? 34'(-diff) : 34'(diff);
  assign out_free = !out_valid_q || out_o.ready;

  assign wdata.x        = in_i.vertex_x;
  assign wdata.y        = in_i.vertex_y;
  assign wdata.internal = in_i.edge_internal;

  always_comb begin
    mop_a = 35'(rdata.x);
    mop_b = ax_q;
    case (state_q)
      cpsat_pkg::S_PMY: begin
        mop_a = 35'(rdata.y);
        mop_b = ay_q;
      end
      cpsat_pkg::S_SHX: begin
        mop_a = $signed({1'b0, usea_q ? pena_q : pen_q});
        mop_b = usea_q ? aax_q : bax_q;
      end
      cpsat_pkg::S_SHY: begin
        mop_a = $signed({1'b0, usea_q ? pena_q : pen_q});
        mop_b = usea_q ? aay_q : bay_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cpsat_pkg::S_IDLE:    if (in_acc && in_i.last_vertex) state_d = cpsat_pkg::S_START;
      cpsat_pkg::S_START:   state_d = (na_q == '0 || nb_q == '0) ? cpsat_pkg::S_OUT
                                                                : cpsat_pkg::S_EDGE_I;
      cpsat_pkg::S_EDGE_I:  state_d = cpsat_pkg::S_EDGE_J;
      cpsat_pkg::S_EDGE_J:  state_d = cpsat_pkg::S_EDGE_N;
      cpsat_pkg::S_EDGE_N:  state_d = cpsat_pkg::S_NORM_GO;
      cpsat_pkg::S_NORM_GO: state_d = cpsat_pkg::S_NORM_W;
      cpsat_pkg::S_NORM_W:  if (norm_done) state_d = cpsat_pkg::S_PRD;
      cpsat_pkg::S_PRD:     state_d = cpsat_pkg::S_PMX;
      cpsat_pkg::S_PMX:     state_d = cpsat_pkg::S_PMY;
      cpsat_pkg::S_PMY:     state_d = cpsat_pkg::S_PCMP;
      cpsat_pkg::S_PCMP:    state_d = (k_q + 1'b1 == ncur && ph_q) ? cpsat_pkg::S_CHECK
                                                                   : cpsat_pkg::S_PRD;
      cpsat_pkg::S_CHECK: begin
        if (gap) state_d = cpsat_pkg::S_OUT;
        else if (i_q + 1'b1 == np && dir_q) state_d = cpsat_pkg::S_SHX;
        else state_d = cpsat_pkg::S_EDGE_I;
      end
      cpsat_pkg::S_SHX:     state_d = cpsat_pkg::S_SHY;
      cpsat_pkg::S_SHY:     state_d = cpsat_pkg::S_SHR;
      cpsat_pkg::S_SHR:     state_d = cpsat_pkg::S_OUT;
      cpsat_pkg::S_OUT:     if (out_free) state_d = cpsat_pkg::S_IDLE;
      default:              state_d = cpsat_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready = (state_q == cpsat_pkg::S_IDLE);
    norm_start = (state_q == cpsat_pkg::S_NORM_GO);
    we         = in_acc && ((in_i.polygon_select ? nb_q : na_q) < cpsat_pkg::MAX_VERT);
    waddr      = {in_i.polygon_select, (in_i.polygon_select ? nb_q[cpsat_pkg::IW-1:0]
                                                            : na_q[cpsat_pkg::IW-1:0])};
    unique case (state_q)
      cpsat_pkg::S_EDGE_I: raddr = {psel, i_q[cpsat_pkg::IW-1:0]};
      cpsat_pkg::S_EDGE_J: raddr = {psel, j_idx[cpsat_pkg::IW-1:0]};
      default:             raddr = {csel, k_q[cpsat_pkg::IW-1:0]};
    endcase
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.collides = out_coll_q;
  assign out_o.shift_x  = out_x_q;
  assign out_o.shift_y  = out_y_q;

  cpsat_vmem u_vmem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  cpsat_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (norm_start),
    .nx_i    (nx_q),
    .ny_i    (ny_q),
    .done_o  (norm_done),
    .ax_o    (norm_ax),
    .ay_o    (norm_ay)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cpsat_pkg::S_IDLE;
      na_q        <= '0;
      nb_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (we) begin
        if (in_i.polygon_select) nb_q <= nb_q + 1'b1;
        else na_q <= na_q + 1'b1;
      end
      if (state_q == cpsat_pkg::S_OUT && out_free) begin
        out_valid_q <= 1'b1;
        na_q        <= '0;
        nb_q        <= '0;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      cpsat_pkg::S_START: begin
        dir_q      <= 1'b0;
        i_q        <= '0;
        first_q    <= 1'b1;
        pen_q      <= '0;
        bax_q      <= '0;
        bay_q      <= '0;
        res_coll_q <= 1'b0;
        resx_q     <= '0;
        resy_q     <= '0;
      end
      cpsat_pkg::S_EDGE_J: begin
        xi_q  <= rdata.x;
        yi_q  <= rdata.y;
        int_q <= rdata.internal;
      end
      cpsat_pkg::S_EDGE_N: begin
        nx_q <= 17'(yi_q) - 17'(rdata.y);
        ny_q <= 17'(rdata.x) - 17'(xi_q);
      end
      cpsat_pkg::S_NORM_W: begin
        ax_q <= norm_ax;
        ay_q <= norm_ay;
        ph_q <= 1'b0;
        k_q  <= '0;
      end
      cpsat_pkg::S_PMX: mul_q <= mul;
      cpsat_pkg::S_PMY: dot_q <= mul_q[32:0] + mul[32:0];
      cpsat_pkg::S_PCMP: begin
        if (!ph_q) begin
          if (k_q == '0 || dot_q < pmn_q) pmn_q <= dot_q;
          if (k_q == '0 || dot_q > pmx_q) pmx_q <= dot_q;
        end else begin
          if (k_q == '0 || dot_q < qmn_q) qmn_q <= dot_q;
          if (k_q == '0 || dot_q > qmx_q) qmx_q <= dot_q;
        end
        if (k_q + 1'b1 == ncur) begin
          k_q  <= '0;
          ph_q <= 1'b1;
        end else begin
          k_q <= k_q + 1'b1;
        end
      end
      cpsat_pkg::S_CHECK: begin
        if (!gap) begin
          // best penetration so far in this direction
          if (!int_q && (first_q || pen_now < pen_q)) begin
            first_q <= 1'b0;
            pen_q   <= pen_now;
            bax_q   <= ax_q;
            bay_q   <= ay_q;
          end
          if (i_q + 1'b1 == np) begin
            i_q <= '0;
            if (!dir_q) begin
              dir_q   <= 1'b1;
              first_q <= 1'b1;
              pena_q  <= (!int_q && (first_q || pen_now < pen_q)) ? pen_now : pen_q;
              aax_q   <= (!int_q && (first_q || pen_now < pen_q)) ? ax_q : bax_q;
              aay_q   <= (!int_q && (first_q || pen_now < pen_q)) ? ay_q : bay_q;
              pen_q   <= '0;
              bax_q   <= '0;
              bay_q   <= '0;
            end else begin
              usea_q <= pena_q < ((!int_q && (first_q || pen_now < pen_q)) ? pen_now : pen_q);
            end
          end else begin
            i_q <= i_q + 1'b1;
          end
        end
      end
      cpsat_pkg::S_SHX: mul_q <= mul;
      cpsat_pkg::S_SHY: begin
        resx_q <= rnd_sat(mul_q, usea_q);
        mul_q  <= mul;
      end
      cpsat_pkg::S_SHR: begin
        resy_q     <= rnd_sat(mul_q, usea_q);
        res_coll_q <= 1'b1;
      end
      cpsat_pkg::S_OUT: begin
        // result word moves to the output register once it is free
        if (out_free) begin
          out_coll_q <= res_coll_q;
          out_x_q    <= resx_q;
          out_y_q    <= resy_q;
        end
      end
      default: ;
    endcase
  end

endmodule
